FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks on i_clk, with and without the reset guard
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KABF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define KABF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define KABF_ASSERT(lbl, prop, msg)
`define KABF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: rtl/kabf_pkg.sv
// ----------------------------------------------------------------------------
// kabf_pkg
// types and fixed constants of the angle and gyro bias filter
// ----------------------------------------------------------------------------
package kabf_pkg;

    localparam int EXT_W       = 67;   // working width of signed intermediates
    localparam int MAG_W       = 64;   // operand magnitude width
    localparam int DIG_W       = 16;   // multiplier digit width
    localparam int NDIG        = MAG_W / DIG_W;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int FRAC_W      = 32;
    localparam int DIVD_W      = MAG_W + FRAC_W;
    localparam int DIV_ITERS   = DIVD_W;
    localparam int CNT_W       = 7;
    localparam int IO_W        = 32;
    localparam int DT_W        = 24;
    localparam int NOISE_W     = 24;
    localparam int NOISE_SHIFT = 8;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_Q_ANGLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Q_BIAS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R_MEAS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 2'd3;

    localparam logic [NOISE_W-1:0] Q_ANGLE_RST = 24'd16777;
    localparam logic [NOISE_W-1:0] Q_BIAS_RST  = 24'd50332;
    localparam logic [NOISE_W-1:0] R_MEAS_RST  = 24'd503316;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_MUL,
        S_MRND,
        S_DIV,
        S_DFIN,
        S_WB,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        ST_PRED,
        ST_T,
        ST_P00,
        ST_P11,
        ST_K0,
        ST_K1,
        ST_ANG,
        ST_BIAS,
        ST_C10,
        ST_C00,
        ST_C11,
        ST_C01
    } t_step;

endpackage

FILE: rtl/kalman_angle_bias_filter.sv
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// two-state fixed point kalman filter for tilt angle and gyro bias
// ----------------------------------------------------------------------------
// One beat in gives one beat out: the filtered angle and the bias-corrected
// rate. Each beat runs twelve steps through one shared 64x16 multiplier (four
// digits per product plus issue, rounding and write-back) and a restoring
// divider that makes one quotient bit a cycle, 96 bits for each of the two
// gains. The input is not ready while a beat is being worked on; a finished
// result waits in the output register. Writing the start angle register loads
// the angle estimate at once. A zero innovation variance gives zero gain.
module kalman_angle_bias_filter
    import kabf_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int COV_WIDTH  = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [IO_W-1:0]      i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [IO_W-1:0] i_measured_angle,
    input  logic signed [IO_W-1:0] i_measured_rate,
    input  logic [DT_W-1:0]      i_time_step,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [IO_W-1:0] o_filtered_angle,
    output logic signed [IO_W-1:0] o_unbiased_rate
);

    `include "assert_macros.svh"

    function automatic logic signed [EXT_W-1:0] sat_w(
        input logic signed [EXT_W-1:0] x,
        input int                      w
    );
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = $signed((EXT_W'(1) << (w - 1)) - EXT_W'(1));
        lo = ~hi;
        if (x > hi) begin
            return hi;
        end else if (x < lo) begin
            return lo;
        end
        return x;
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [EXT_W-1:0] x);
        logic [EXT_W-1:0] a;
        a = (x < 0) ? $unsigned(-x) : $unsigned(x);
        return a[MAG_W-1:0];
    endfunction

    t_state r_state, n_state;
    t_step  r_step;
    logic [CNT_W-1:0] r_cnt;

    logic [NOISE_W-1:0] r_q_angle, r_q_bias, r_r_meas;

    logic signed [DATA_WIDTH-1:0] r_ang, r_bias, r_rate, r_y;
    logic signed [COV_WIDTH-1:0]  r_p00, r_p01, r_p10, r_p11;
    logic signed [COV_WIDTH-1:0]  r_inner, r_s, r_k0, r_k1;
    logic signed [IO_W-1:0]       r_ma;
    logic [DT_W-1:0]              r_dt;

    // shared unit registers
    logic [MAG_W-1:0]  r_ma_mag, r_mb_mag;
    logic              r_neg;
    logic [PROD_W-1:0] r_acc;
    logic [DIVD_W-1:0] r_dn;
    logic [MAG_W-1:0]  r_dd, r_rem, r_q;
    logic              r_over, r_dzero;
    logic signed [EXT_W-1:0] r_m;

    logic                r_out_valid;
    logic signed [IO_W-1:0] r_out_angle, r_out_rate;

    logic signed [EXT_W-1:0] op_a, op_b;
    int                      mul_sh, mul_w;
    logic                    is_div, last_step;

    // operand selection per step
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        mul_sh = FRAC_W;
        mul_w  = COV_WIDTH;
        is_div = 1'b0;
        unique case (r_step)
            ST_PRED: begin
                op_a = $signed(EXT_W'(r_dt));
                op_b = EXT_W'(r_rate);
                mul_sh = DT_W;
                mul_w  = MAG_W;
            end
            ST_T: begin
                op_a = $signed(EXT_W'(r_dt));
                op_b = EXT_W'(r_p11);
                mul_sh = DT_W;
            end
            ST_P00: begin
                op_a = $signed(EXT_W'(r_dt));
                op_b = EXT_W'(r_inner);
                mul_sh = DT_W;
            end
            ST_P11: begin
                op_a = $signed(EXT_W'(r_q_bias));
                op_b = $signed(EXT_W'(r_dt));
                mul_sh = DT_W - NOISE_SHIFT;
            end
            ST_K0: begin
                op_a = EXT_W'(r_p00);
                op_b = EXT_W'(r_s);
                is_div = 1'b1;
            end
            ST_K1: begin
                op_a = EXT_W'(r_p10);
                op_b = EXT_W'(r_s);
                is_div = 1'b1;
            end
            ST_ANG: begin
                op_a = EXT_W'(r_k0);
                op_b = EXT_W'(r_y);
                mul_w = DATA_WIDTH;
            end
            ST_BIAS: begin
                op_a = EXT_W'(r_k1);
                op_b = EXT_W'(r_y);
                mul_w = DATA_WIDTH;
            end
            ST_C10: begin
                op_a = EXT_W'(r_k1);
                op_b = EXT_W'(r_p00);
            end
            ST_C00: begin
                op_a = EXT_W'(r_k0);
                op_b = EXT_W'(r_p00);
            end
            ST_C11: begin
                op_a = EXT_W'(r_k1);
                op_b = EXT_W'(r_p01);
            end
            ST_C01: begin
                op_a = EXT_W'(r_k0);
                op_b = EXT_W'(r_p01);
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    assign last_step = (r_step == ST_C01);

    // product rounding, ties away from zero on the magnitude
    logic [PROD_W-1:0]       rnd_sum, rnd_q;
    logic [MAG_W+1:0]        rnd_c;
    logic signed [EXT_W-1:0] rnd_val;

    always_comb begin
        rnd_sum = r_acc + (PROD_W'(1) << (mul_sh - 1));
        rnd_q   = rnd_sum >> mul_sh;
        rnd_c   = (|rnd_q[PROD_W-1:MAG_W+1]) ? {1'b1, {(MAG_W+1){1'b0}}}
                                              : rnd_q[MAG_W+1:0];
        rnd_val = r_neg ? -$signed({1'b0, rnd_c}) : $signed({1'b0, rnd_c});
    end

    // quotient conversion
    logic [MAG_W+1:0]        div_c;
    logic signed [EXT_W-1:0] div_val;

    always_comb begin
        div_c   = r_over ? {1'b1, {(MAG_W+1){1'b0}}} : {2'b00, r_q};
        div_val = r_neg ? -$signed({1'b0, div_c}) : $signed({1'b0, div_c});
    end

    // one restoring step
    logic [MAG_W:0] rem_sh, rem_sub;
    logic           rem_ge;

    always_comb begin
        rem_sh  = {r_rem, r_dn[DIVD_W-1]};
        rem_ge  = (rem_sh >= {1'b0, r_dd});
        rem_sub = rem_sh - {1'b0, r_dd};
    end

    // write-back helpers
    logic signed [EXT_W-1:0] wb_t1, wb_t2, wb_inner, wb_p00, wb_s, wb_rate, wb_y;

    always_comb begin
        wb_t1    = sat_w(r_m - EXT_W'(r_p01), COV_WIDTH);
        wb_t2    = sat_w(wb_t1 - EXT_W'(r_p10), COV_WIDTH);
        wb_inner = sat_w(wb_t2 + $signed(EXT_W'(r_q_angle) << NOISE_SHIFT), COV_WIDTH);
        wb_p00   = sat_w(EXT_W'(r_p00) + r_m, COV_WIDTH);
        wb_s     = sat_w(wb_p00 + $signed(EXT_W'(r_r_meas) << NOISE_SHIFT), COV_WIDTH);
        wb_rate  = sat_w(EXT_W'(i_measured_rate) - EXT_W'(r_bias), DATA_WIDTH);
        wb_y     = sat_w(EXT_W'(r_ma) - EXT_W'(r_ang), DATA_WIDTH);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_ISSUE;
            S_ISSUE: n_state = is_div ? S_DIV : S_MUL;
            S_MUL:   if (r_cnt == CNT_W'(NDIG - 1)) n_state = S_MRND;
            S_MRND:  n_state = S_WB;
            S_DIV:   if (r_cnt == CNT_W'(DIV_ITERS - 1)) n_state = S_DFIN;
            S_DFIN:  n_state = S_WB;
            S_WB:    n_state = last_step ? S_DONE : S_ISSUE;
            S_DONE:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready       = (r_state == S_IDLE);
        o_out_valid      = r_out_valid;
        o_filtered_angle = r_out_angle;
        o_unbiased_rate  = r_out_rate;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_PRED;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_q_angle   <= Q_ANGLE_RST;
            r_q_bias    <= Q_BIAS_RST;
            r_r_meas    <= R_MEAS_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_ISSUE || r_state == S_MRND || r_state == S_DFIN) begin
                r_cnt <= '0;
            end else if (r_state == S_MUL || r_state == S_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_state == S_IDLE) begin
                r_step <= ST_PRED;
            end else if (r_state == S_WB && !last_step) begin
                r_step <= t_step'(r_step + 4'd1);
            end
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wen) begin
                unique case (i_cfg_idx)
                    REG_Q_ANGLE: r_q_angle <= i_cfg_data[NOISE_W-1:0];
                    REG_Q_BIAS:  r_q_bias  <= i_cfg_data[NOISE_W-1:0];
                    REG_R_MEAS:  r_r_meas  <= i_cfg_data[NOISE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang  <= '0;
            r_bias <= '0;
            r_p00  <= '0;
            r_p01  <= '0;
            r_p10  <= '0;
            r_p11  <= '0;
        end else if (i_cfg_wen && i_cfg_idx == REG_START_ANGLE) begin
            r_ang <= DATA_WIDTH'(sat_w(EXT_W'($signed(i_cfg_data)), DATA_WIDTH));
        end else if (r_state == S_WB) begin
            unique case (r_step)
                ST_PRED: r_ang <= DATA_WIDTH'(sat_w(EXT_W'(r_ang) + r_m, DATA_WIDTH));
                ST_T: begin
                    r_p01 <= COV_WIDTH'(sat_w(EXT_W'(r_p01) - r_m, COV_WIDTH));
                    r_p10 <= COV_WIDTH'(sat_w(EXT_W'(r_p10) - r_m, COV_WIDTH));
                end
                ST_P00:  r_p00 <= COV_WIDTH'(wb_p00);
                ST_P11:  r_p11 <= COV_WIDTH'(sat_w(EXT_W'(r_p11) + r_m, COV_WIDTH));
                ST_ANG:  r_ang <= DATA_WIDTH'(sat_w(EXT_W'(r_ang) + r_m, DATA_WIDTH));
                ST_BIAS: r_bias <= DATA_WIDTH'(sat_w(EXT_W'(r_bias) + r_m, DATA_WIDTH));
                ST_C10:  r_p10 <= COV_WIDTH'(sat_w(EXT_W'(r_p10) - r_m, COV_WIDTH));
                ST_C00:  r_p00 <= COV_WIDTH'(sat_w(EXT_W'(r_p00) - r_m, COV_WIDTH));
                ST_C11:  r_p11 <= COV_WIDTH'(sat_w(EXT_W'(r_p11) - r_m, COV_WIDTH));
                ST_C01:  r_p01 <= COV_WIDTH'(sat_w(EXT_W'(r_p01) - r_m, COV_WIDTH));
                default: begin
                end
            endcase
        end
    end

    // working registers and shared unit
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_ma   <= i_measured_angle;
            r_dt   <= i_time_step;
            r_rate <= DATA_WIDTH'(wb_rate);
        end
        if (r_state == S_WB) begin
            case (r_step)
                ST_T:   r_inner <= COV_WIDTH'(wb_inner);
                ST_P00: r_s     <= COV_WIDTH'(wb_s);
                ST_K0:  r_k0    <= COV_WIDTH'(r_m);
                ST_K1: begin
                    r_k1 <= COV_WIDTH'(r_m);
                    r_y  <= DATA_WIDTH'(wb_y);
                end
                default: begin
                end
            endcase
        end
        if (r_state == S_ISSUE) begin
            r_neg    <= (op_a < 0) != (op_b < 0);
            r_ma_mag <= mag(op_a);
            r_mb_mag <= mag(op_b);
            r_acc    <= '0;
            r_dn     <= {mag(op_a), {FRAC_W{1'b0}}};
            r_dd     <= mag(op_b);
            r_rem    <= '0;
            r_q      <= '0;
            r_over   <= 1'b0;
            r_dzero  <= (op_b == 0);
        end
        if (r_state == S_MUL) begin
            // most significant digit first
            r_acc    <= (r_acc << DIG_W)
                        + PROD_W'(r_ma_mag * r_mb_mag[MAG_W-1 -: DIG_W]);
            r_mb_mag <= r_mb_mag << DIG_W;
        end
        if (r_state == S_DIV) begin
            r_dn   <= r_dn << 1;
            r_over <= r_over | r_q[MAG_W-1];
            if (rem_ge) begin
                r_rem <= rem_sub[MAG_W-1:0];
                r_q   <= {r_q[MAG_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[MAG_W-1:0];
                r_q   <= {r_q[MAG_W-2:0], 1'b0};
            end
        end
        if (r_state == S_MRND) begin
            r_m <= sat_w(rnd_val, mul_w);
        end
        if (r_state == S_DFIN) begin
            r_m <= r_dzero ? '0 : sat_w(div_val, COV_WIDTH);
        end
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_angle <= IO_W'(sat_w(EXT_W'(r_ang), IO_W));
            r_out_rate  <= IO_W'(sat_w(EXT_W'(r_rate), IO_W));
        end
    end

    `KABF_ASSERT(a_accept_starts, (i_in_valid && o_in_ready) |=> (r_state == S_ISSUE && r_step == ST_PRED), "accepted beat did not start the sequence")
    `KABF_ASSERT(a_mul_cnt, (r_state == S_MUL) |-> (r_cnt < CNT_W'(NDIG)), "multiplier digit count overrun")
    `KABF_ASSERT(a_out_from_done, $rose(o_out_valid) |-> ($past(r_state) == S_DONE), "result shown outside done")
    `KABF_ASSERT(a_zero_gain, (r_state == S_DFIN && r_dzero) |=> (r_m == '0), "zero divisor gave nonzero gain")
    `KABF_ASSERT_RST(a_reset, !i_rst_n |=> (r_state == S_IDLE && !o_out_valid), "reset did not clear control")

endmodule
